FILE: design/vbm_pkg.sv
// ----------------------------------------------------------------------------
// vbm_pkg
// Shared types, codes and bank tables for the video memory bank mapper.
// ----------------------------------------------------------------------------
package vbm_pkg;

  localparam int NBANKS = 9;
  localparam int BASE_W = 27;
  localparam int OFFSET_W = 20;
  localparam int BANK_W = 4;
  localparam logic [31:0] CTRL_BASE = 32'h0400_0240;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_READ       = 2'd1,
    OP_XLATE_MAIN = 2'd2,
    OP_XLATE_SUB  = 2'd3
  } op_t;

  localparam logic [BANK_W-1:0] BANK_A = 4'd0;
  localparam logic [BANK_W-1:0] BANK_B = 4'd1;
  localparam logic [BANK_W-1:0] BANK_C = 4'd2;
  localparam logic [BANK_W-1:0] BANK_D = 4'd3;
  localparam logic [BANK_W-1:0] BANK_E = 4'd4;
  localparam logic [BANK_W-1:0] BANK_F = 4'd5;
  localparam logic [BANK_W-1:0] BANK_G = 4'd6;
  localparam logic [BANK_W-1:0] BANK_H = 4'd7;
  localparam logic [BANK_W-1:0] BANK_I = 4'd8;

  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
    logic [7:0]        value;
  } wr_req_t;

  typedef struct packed {
    logic [NBANKS-1:0][7:0]        ctrl;
    logic [NBANKS-1:0][BASE_W-1:0] base;
    logic [1:0]                    owned;
  } bank_state_t;

  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } ctrl_sel_t;

  function automatic ctrl_sel_t ctrl_bank(logic [31:0] a);
    ctrl_sel_t s;
    s.valid = 1'b1;
    s.bank  = BANK_A;
    if (a >= CTRL_BASE && a <= CTRL_BASE + 32'd6) begin
      s.bank = BANK_W'(a - CTRL_BASE);
    end else if (a == CTRL_BASE + 32'd8) begin
      s.bank = BANK_H;
    end else if (a == CTRL_BASE + 32'd9) begin
      s.bank = BANK_I;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

  function automatic logic [31:0] bank_size(logic [BANK_W-1:0] b);
    logic [31:0] s;
    case (b)
      BANK_A, BANK_B, BANK_C, BANK_D: s = 32'h0002_0000;
      BANK_E: s = 32'h0001_0000;
      BANK_H: s = 32'h0000_8000;
      default: s = 32'h0000_4000;
    endcase
    return s;
  endfunction

  function automatic logic [OFFSET_W-1:0] flat_base(logic [BANK_W-1:0] b);
    logic [OFFSET_W-1:0] f;
    case (b)
      BANK_A: f = 20'h00000;
      BANK_B: f = 20'h20000;
      BANK_C: f = 20'h40000;
      BANK_D: f = 20'h60000;
      BANK_E: f = 20'h80000;
      BANK_F: f = 20'h90000;
      BANK_G: f = 20'h94000;
      BANK_H: f = 20'h98000;
      default: f = 20'hA0000;
    endcase
    return f;
  endfunction

endpackage

FILE: design/vram_bank_mapper_unit.sv
// ----------------------------------------------------------------------------
// vram_bank_mapper_unit
// Video memory bank controller: control byte writes and reads, and bus
// address translation into the flat store of nine banks.
// ----------------------------------------------------------------------------
// Flow: a request accepted into the input register moves on into the result
// register once that register is empty or its result is being taken.
// Throughput: one request per cycle while results are taken; the single translate
// and update stage between the input and result registers sets that figure.
// Reset: synchronous, active high; control bytes, window bases, ownership
// flags and both valid flags clear together.
module vram_bank_mapper_unit
  import vbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // address[31:0], ctrl_value[39:32]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // vram_offset[19:0], bank_index[23:20], read_data[31:24]
  output logic        m_axis_tuser   // hit[0]
);

  logic                in_valid;
  op_t                 in_op;
  logic [31:0]         in_addr;
  logic [7:0]          in_value;
  logic                out_valid;
  logic                out_hit;
  logic [OFFSET_W-1:0] out_offset;
  logic [BANK_W-1:0]   out_bank;
  logic [7:0]          out_rdata;
  logic                advance;
  ctrl_sel_t           sel;
  wr_req_t             wr;
  bank_state_t         state;
  logic                x_hit;
  logic [OFFSET_W-1:0] x_offset;
  logic [BANK_W-1:0]   x_bank;
  logic                is_xlate;

  assign advance = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign sel = ctrl_bank(in_addr);
  assign is_xlate = (in_op == OP_XLATE_MAIN) || (in_op == OP_XLATE_SUB);

  assign wr.en = advance && (in_op == OP_WRITE) && sel.valid;
  assign wr.bank = sel.bank;
  assign wr.value = in_value;

  vbm_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .state (state)
  );

  vbm_xlate u_xlate (
    .op          (in_op),
    .address     (in_addr),
    .state       (state),
    .hit         (x_hit),
    .vram_offset (x_offset),
    .bank_index  (x_bank)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op    <= op_t'(s_axis_tuser);
      in_addr  <= s_axis_tdata[31:0];
      in_value <= s_axis_tdata[39:32];
    end
    if (advance) begin
      out_hit    <= is_xlate && x_hit;
      out_offset <= is_xlate ? x_offset : '0;
      out_bank   <= is_xlate ? x_bank : BANK_A;
      out_rdata  <= (in_op == OP_READ && sel.valid) ? state.ctrl[sel.bank] : 8'h00;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_hit;
  assign m_axis_tdata  = {out_rdata, out_bank, out_offset};

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hit |-> out_offset == '0 && out_bank == BANK_A)
    else $error("miss result carries a nonzero offset or bank");

  a_hit_no_rdata: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_hit |-> out_rdata == 8'h00 && out_bank <= BANK_I)
    else $error("translate result mixed with read data or bad bank");

  a_own_c: assert property (@(posedge clk) disable iff (rst)
    state.owned[0] |-> state.ctrl[BANK_C][2:0] == 3'd2)
    else $error("bank C owned without second CPU mode");

  a_own_d: assert property (@(posedge clk) disable iff (rst)
    state.owned[1] |-> state.ctrl[BANK_D][2:0] == 3'd2)
    else $error("bank D owned without second CPU mode");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !m_axis_tready |=> in_valid && out_valid)
    else $error("request lost while the result stalled");

endmodule

FILE: design/vbm_regs.sv
// ----------------------------------------------------------------------------
// vbm_regs
// Bank control bytes, bus window bases and second CPU ownership flags.
// ----------------------------------------------------------------------------
module vbm_regs
  import vbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  wr_req_t     wr,
  output bank_state_t state
);

  logic [NBANKS-1:0][7:0]        ctrl;
  logic [NBANKS-1:0][BASE_W-1:0] base;
  logic [1:0]                    owned;
  logic [BASE_W-1:0]             base_next;
  logic                          base_load;
  logic                          own_set;
  logic [1:0]                    m2;
  logic [2:0]                    m3;
  logic [1:0]                    ofs;
  logic [BASE_W-1:0]             big_step;
  logic [BASE_W-1:0]             half_step;
  logic [BASE_W-1:0]             small_step;

  assign m2 = wr.value[1:0];
  assign m3 = wr.value[2:0];
  assign ofs = wr.value[4:3];
  assign big_step = BASE_W'({ofs, 17'b0});
  assign half_step = BASE_W'({ofs[0], 17'b0});
  assign small_step = BASE_W'({ofs[1], 1'b0, ofs[0], 14'b0});

  always_comb begin
    base_next = base[wr.bank];
    base_load = 1'b1;
    own_set   = 1'b0;
    case (wr.bank)
      BANK_A, BANK_B: begin
        case (m2)
          2'd0: base_next = (wr.bank == BANK_A) ? 27'h680_0000 : 27'h682_0000;
          2'd1: base_next = 27'h600_0000 + big_step;
          2'd2: base_next = 27'h640_0000 + half_step;
          default: base_load = 1'b0;
        endcase
      end
      BANK_C, BANK_D: begin
        case (m3)
          3'd0: base_next = (wr.bank == BANK_C) ? 27'h684_0000 : 27'h686_0000;
          3'd1: base_next = 27'h600_0000 + big_step;
          3'd2: begin
            base_next = 27'h600_0000 + half_step;
            own_set   = 1'b1;
          end
          3'd4: base_next = (wr.bank == BANK_C) ? 27'h620_0000 : 27'h660_0000;
          default: base_load = 1'b0;
        endcase
      end
      BANK_E: begin
        case (m3)
          3'd0: base_next = 27'h688_0000;
          3'd1: base_next = 27'h600_0000;
          3'd2: base_next = 27'h640_0000;
          default: base_load = 1'b0;
        endcase
      end
      BANK_F, BANK_G: begin
        case (m3)
          3'd0: base_next = (wr.bank == BANK_F) ? 27'h689_0000 : 27'h689_4000;
          3'd1: base_next = 27'h600_0000 + small_step;
          3'd2: base_next = 27'h640_0000 + small_step;
          default: base_load = 1'b0;
        endcase
      end
      BANK_H: begin
        case (m2)
          2'd0: base_next = 27'h689_8000;
          2'd1: base_next = 27'h620_0000;
          default: base_load = 1'b0;
        endcase
      end
      default: begin
        case (m2)
          2'd0: base_next = 27'h68A_0000;
          2'd1: base_next = 27'h620_8000;
          2'd2: base_next = 27'h660_0000;
          default: base_load = 1'b0;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl  <= '0;
      base  <= '0;
      owned <= 2'b00;
    end else if (wr.en) begin
      ctrl[wr.bank] <= wr.value;
      if (base_load) begin
        base[wr.bank] <= base_next;
      end
      if (wr.bank == BANK_C) begin
        owned[0] <= own_set;
      end
      if (wr.bank == BANK_D) begin
        owned[1] <= own_set;
      end
    end
  end

  assign state.ctrl  = ctrl;
  assign state.base  = base;
  assign state.owned = owned;

endmodule

FILE: design/vbm_xlate.sv
// ----------------------------------------------------------------------------
// vbm_xlate
// Priority window match of a bus address over the nine banks.
// ----------------------------------------------------------------------------
module vbm_xlate
  import vbm_pkg::*;
(
  input  op_t                 op,
  input  logic [31:0]         address,
  input  bank_state_t         state,
  output logic                hit,
  output logic [OFFSET_W-1:0] vram_offset,
  output logic [BANK_W-1:0]   bank_index
);

  logic [NBANKS-1:0] match;

  always_comb begin
    logic [31:0] lo;
    logic [31:0] size;
    logic        cd;
    logic        own;
    logic        usable;
    for (int i = 0; i < NBANKS; i++) begin
      lo   = {{(32 - BASE_W){1'b0}}, state.base[i]};
      size = bank_size(BANK_W'(i));
      cd   = (i == 2) || (i == 3);
      own  = (i == 2) ? state.owned[0] : ((i == 3) ? state.owned[1] : 1'b0);
      if (op == OP_XLATE_MAIN) begin
        usable = !(cd && own);
      end else begin
        usable = cd && own;
      end
      match[i] = usable && (address >= lo) && (address < lo + size);
    end
  end

  always_comb begin
    logic        found;
    logic [19:0] mask;
    found       = 1'b0;
    vram_offset = '0;
    bank_index  = BANK_A;
    for (int i = 0; i < NBANKS; i++) begin
      mask = OFFSET_W'(bank_size(BANK_W'(i)) - 32'd1);
      if (!found && match[i]) begin
        found       = 1'b1;
        vram_offset = flat_base(BANK_W'(i)) + (address[OFFSET_W-1:0] & mask);
        bank_index  = BANK_W'(i);
      end
    end
    hit = found;
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for the video memory bank mapper. A short table of
// directed requests covers reset windows, mode extremes and unknown control
// addresses, then random control writes, reads and translations aimed at the
// live bank windows run under three idling profiles. Every result is checked
// field by field against a table result or the bench's bank state predictor.
// ----------------------------------------------------------------------------
module tb;
  import vbm_pkg::*;

  typedef struct packed {
    logic                hit;
    logic [OFFSET_W-1:0] offset;
    logic [BANK_W-1:0]   bank;
    logic [7:0]          rdata;
  } xlate_res_t;

  typedef struct packed {
    op_t        op;
    logic [31:0] addr;
    logic [7:0]  value;
    logic        typed;
    xlate_res_t  res;
  } stim_row_t;

  localparam xlate_res_t NO_RESULT = '0;
  localparam logic [31:0] CTRL_GAP = CTRL_BASE + 32'd7;
  localparam logic [31:0] CTRL_PAST = CTRL_BASE + 32'd10;
  localparam logic [2:0] MST_HOME = 3'd0;
  localparam logic [2:0] MST_LOW = 3'd1;
  localparam logic [2:0] MST_HIGH = 3'd2;
  localparam logic [2:0] MST_EXTRA = 3'd4;
  localparam int RAND_PER_PHASE = 570;
  localparam int DIR_N = 27;

  localparam logic [NBANKS-1:0][31:0] BANK_BYTES = {
    32'h4000, 32'h8000, 32'h4000, 32'h4000, 32'h10000,
    32'h20000, 32'h20000, 32'h20000, 32'h20000};
  localparam logic [NBANKS-1:0][OFFSET_W-1:0] BANK_FLAT = {
    20'hA0000, 20'h98000, 20'h94000, 20'h90000, 20'h80000,
    20'h60000, 20'h40000, 20'h20000, 20'h00000};

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [7:0]  ctrl_byte [NBANKS];
  logic [31:0] win_base [NBANKS];
  logic        sub_owned [2];

  xlate_res_t  pending_q [$];
  xlate_res_t  got_res;
  xlate_res_t  want_res;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          fail_cnt = 0;
  int          n_writes = 0;
  int          n_reads = 0;
  int          n_hits = 0;
  int          n_sub_hits = 0;
  int          n_misses = 0;

  vram_bank_mapper_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  function automatic logic [31:0] ctrl_addr(logic [BANK_W-1:0] b);
    return (b <= BANK_G) ? CTRL_BASE + 32'(b) : CTRL_BASE + 32'(b) + 32'd1;
  endfunction

  stim_row_t dir_rows [DIR_N] = '{
    '{OP_READ, ctrl_addr(BANK_A), 8'h5A, 1'b1, NO_RESULT},
    '{OP_XLATE_MAIN, 32'h0000_0000, 8'h00, 1'b1, '{1'b1, 20'h00000, BANK_A, 8'h00}},
    '{OP_XLATE_MAIN, 32'h0001_FFFF, 8'h00, 1'b1, '{1'b1, 20'h1FFFF, BANK_A, 8'h00}},
    '{OP_XLATE_MAIN, 32'h0002_0000, 8'h00, 1'b1, NO_RESULT},
    '{OP_XLATE_SUB, 32'h0000_0000, 8'h00, 1'b1, NO_RESULT},
    '{OP_XLATE_MAIN, 32'hFFFF_FFFF, 8'hFF, 1'b1, NO_RESULT},
    '{OP_WRITE, ctrl_addr(BANK_A), 8'h00, 1'b1, NO_RESULT},
    '{OP_WRITE, ctrl_addr(BANK_B), 8'hFF, 1'b1, NO_RESULT},
    '{OP_READ, ctrl_addr(BANK_B), 8'h00, 1'b1, '{1'b0, 20'h0, BANK_A, 8'hFF}},
    '{OP_WRITE, ctrl_addr(BANK_C), 8'h12, 1'b1, NO_RESULT},
    '{OP_XLATE_SUB, 32'h0600_0010, 8'h00, 1'b1, '{1'b1, 20'h40010, BANK_C, 8'h00}},
    '{OP_XLATE_MAIN, 32'h0600_0010, 8'h00, 1'b0, NO_RESULT},
    '{OP_WRITE, ctrl_addr(BANK_D), 8'h04, 1'b0, NO_RESULT},
    '{OP_WRITE, ctrl_addr(BANK_E), 8'h02, 1'b0, NO_RESULT},
    '{OP_WRITE, ctrl_addr(BANK_F), 8'h19, 1'b0, NO_RESULT},
    '{OP_WRITE, ctrl_addr(BANK_G), 8'h0A, 1'b0, NO_RESULT},
    '{OP_WRITE, ctrl_addr(BANK_H), 8'h01, 1'b0, NO_RESULT},
    '{OP_WRITE, ctrl_addr(BANK_I), 8'h02, 1'b0, NO_RESULT},
    '{OP_WRITE, CTRL_GAP, 8'hAA, 1'b1, NO_RESULT},
    '{OP_READ, CTRL_GAP, 8'h00, 1'b1, NO_RESULT},
    '{OP_READ, CTRL_PAST, 8'h00, 1'b1, NO_RESULT},
    '{OP_READ, ctrl_addr(BANK_I), 8'h00, 1'b1, '{1'b0, 20'h0, BANK_A, 8'h02}},
    '{OP_XLATE_MAIN, 32'h0660_0000, 8'h00, 1'b0, NO_RESULT},
    '{OP_XLATE_MAIN, 32'h0681_4000, 8'h00, 1'b0, NO_RESULT},
    '{OP_XLATE_MAIN, 32'h0640_4000, 8'h00, 1'b0, NO_RESULT},
    '{OP_WRITE, ctrl_addr(BANK_C), 8'h04, 1'b0, NO_RESULT},
    '{OP_XLATE_SUB, 32'h0600_0010, 8'h00, 1'b1, NO_RESULT}
  };

  function automatic xlate_res_t map_request(op_t op, logic [31:0] a, logic [7:0] v);
    xlate_res_t r;
    int         slot;
    logic [1:0] m2;
    logic [2:0] m3;
    logic [1:0] ofs;
    logic [31:0] nudge;
    logic       usable;
    logic       found;
    r = NO_RESULT;
    slot = -1;
    if (a >= CTRL_BASE && a < CTRL_GAP) slot = int'(a - CTRL_BASE);
    else if (a == ctrl_addr(BANK_H)) slot = BANK_H;
    else if (a == ctrl_addr(BANK_I)) slot = BANK_I;
    m2 = v[1:0];
    m3 = v[2:0];
    ofs = v[4:3];
    nudge = 32'h4000 * ofs[0] + 32'h10000 * ofs[1];
    found = 1'b0;
    case (op)
      OP_WRITE: begin
        if (slot >= 0) begin
          ctrl_byte[slot] = v;
          case (slot)
            BANK_A, BANK_B: begin
              if (m2 == MST_HOME[1:0])
                win_base[slot] = (slot == BANK_A) ? 32'h0680_0000 : 32'h0682_0000;
              else if (m2 == MST_LOW[1:0]) win_base[slot] = 32'h0600_0000 + 32'h20000 * ofs;
              else if (m2 == MST_HIGH[1:0])
                win_base[slot] = 32'h0640_0000 + 32'h20000 * ofs[0];
            end
            BANK_C, BANK_D: begin
              sub_owned[slot - BANK_C] = 1'b0;
              if (m3 == MST_HOME)
                win_base[slot] = (slot == BANK_C) ? 32'h0684_0000 : 32'h0686_0000;
              else if (m3 == MST_LOW) win_base[slot] = 32'h0600_0000 + 32'h20000 * ofs;
              else if (m3 == MST_HIGH) begin
                win_base[slot] = 32'h0600_0000 + 32'h20000 * ofs[0];
                sub_owned[slot - BANK_C] = 1'b1;
              end else if (m3 == MST_EXTRA)
                win_base[slot] = (slot == BANK_C) ? 32'h0620_0000 : 32'h0660_0000;
            end
            BANK_E: begin
              if (m3 == MST_HOME) win_base[slot] = 32'h0688_0000;
              else if (m3 == MST_LOW) win_base[slot] = 32'h0600_0000;
              else if (m3 == MST_HIGH) win_base[slot] = 32'h0640_0000;
            end
            BANK_F, BANK_G: begin
              if (m3 == MST_HOME)
                win_base[slot] = (slot == BANK_F) ? 32'h0689_0000 : 32'h0689_4000;
              else if (m3 == MST_LOW) win_base[slot] = 32'h0600_0000 + nudge;
              else if (m3 == MST_HIGH) win_base[slot] = 32'h0640_0000 + nudge;
            end
            BANK_H: begin
              if (m2 == MST_HOME[1:0]) win_base[slot] = 32'h0689_8000;
              else if (m2 == MST_LOW[1:0]) win_base[slot] = 32'h0620_0000;
            end
            default: begin
              if (m2 == MST_HOME[1:0]) win_base[slot] = 32'h068A_0000;
              else if (m2 == MST_LOW[1:0]) win_base[slot] = 32'h0620_8000;
              else if (m2 == MST_HIGH[1:0]) win_base[slot] = 32'h0660_0000;
            end
          endcase
        end
      end
      OP_READ: begin
        if (slot >= 0) r.rdata = ctrl_byte[slot];
      end
      default: begin
        for (int i = 0; i < NBANKS; i++) begin
          if (i == BANK_C || i == BANK_D)
            usable = (op == OP_XLATE_SUB) == sub_owned[i - BANK_C];
          else usable = (op == OP_XLATE_MAIN);
          if (!found && usable && a >= win_base[i] && a < win_base[i] + BANK_BYTES[i]) begin
            found = 1'b1;
            r.hit = 1'b1;
            r.offset = BANK_FLAT[i] + OFFSET_W'(a & (BANK_BYTES[i] - 32'd1));
            r.bank = BANK_W'(i);
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_request(op_t op, logic [31:0] a, logic [7:0] v, logic typed,
                              xlate_res_t typed_res);
    xlate_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v, a};
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = map_request(op, a, v);
    pending_q.push_back(typed ? typed_res : r);
    case (op)
      OP_WRITE: n_writes++;
      OP_READ: n_reads++;
      default: begin
        if (!r.hit) n_misses++;
        else if (op == OP_XLATE_SUB) n_sub_hits++;
        else n_hits++;
      end
    endcase
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_res.hit = m_axis_tuser;
      got_res.offset = m_axis_tdata[19:0];
      got_res.bank = m_axis_tdata[23:20];
      got_res.rdata = m_axis_tdata[31:24];
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got_res);
        fail_cnt++;
      end else begin
        want_res = pending_q.pop_front();
        check_field("hit", want_res.hit, got_res.hit);
        check_field("vram_offset", want_res.offset, got_res.offset);
        check_field("bank_index", want_res.bank, got_res.bank);
        check_field("read_data", want_res.rdata, got_res.rdata);
      end
    end
  end

  initial begin
    int          useful;
    int          k;
    int unsigned pick;
    op_t         op;
    logic [31:0] a;
    logic [7:0]  v;
    logic        ignored;
    for (int i = 0; i < NBANKS; i++) begin
      ctrl_byte[i] = '0;
      win_base[i] = '0;
    end
    sub_owned[0] = 1'b0;
    sub_owned[1] = 1'b0;
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].value, dir_rows[i].typed,
                   dir_rows[i].res);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 22 : 0;
      useful = 0;
      while (useful < RAND_PER_PHASE) begin
        pick = $urandom_range(99);
        v = 8'($urandom);
        ignored = 1'b0;
        k = $urandom_range(NBANKS - 1);
        if (pick < 25) begin
          op = OP_WRITE;
          if ($urandom_range(3) == 0) begin
            k = BANK_C + $urandom_range(1);
            v[2:0] = MST_HIGH;
          end
          a = ctrl_addr(BANK_W'(k));
        end else if (pick < 35) begin
          op = OP_READ;
          a = ctrl_addr(BANK_W'(k));
        end else if (pick < 41) begin
          op = ($urandom_range(1) == 0) ? OP_WRITE : OP_READ;
          case ($urandom_range(2))
            0: a = CTRL_GAP;
            1: a = CTRL_BASE + 32'($urandom_range(15)) - 32'd3;
            default: a = $urandom;
          endcase
          ignored = (op == OP_WRITE) && (a == CTRL_GAP || a < CTRL_BASE || a > CTRL_PAST);
        end else if (pick < 49) begin
          op = ($urandom_range(1) == 0) ? OP_XLATE_MAIN : OP_XLATE_SUB;
          a = $urandom;
        end else begin
          op = (pick < 82) ? OP_XLATE_MAIN : OP_XLATE_SUB;
          if (op == OP_XLATE_SUB) k = BANK_C + $urandom_range(1);
          case ($urandom_range(9))
            0: a = win_base[k] - 32'd1;
            1: a = win_base[k] + BANK_BYTES[k];
            2: a = win_base[k] + BANK_BYTES[k] - 32'd1;
            default: a = win_base[k] + 32'($urandom_range(BANK_BYTES[k] - 1));
          endcase
        end
        send_request(op, a, v, 1'b0, NO_RESULT);
        if (!ignored) useful++;
      end
      if (phase == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d control writes and %0d control reads.", n_writes, n_reads);
    $display("Translations: %0d main CPU hits, %0d second CPU hits, %0d misses.",
             n_hits, n_sub_hits, n_misses);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
